// File: src/pctc_pkg.sv
`timescale 1ns / 1ps
package pctc_pkg;

    localparam logic [31:0] MagLimit = 32'd10000000;
    localparam logic [31:0] Ovr0A = 32'd1000017;
    localparam logic [31:0] Ovr0B = 32'd1000018;
    localparam logic [31:0] Ovr0C = 32'd1000034;
    localparam logic [31:0] Ovr0D = 32'd1000052;
    localparam logic [31:0] Ovr0E = 32'd1000053;
    localparam logic [31:0] Ovr0F = 32'd1000054;
    localparam logic [31:0] Ovr6A = 32'd5100061;
    localparam logic [31:0] Ovr6B = 32'd5100062;
    localparam logic [31:0] FidMax = 32'd102;
    localparam logic [6:0] FidTop = 7'd100;

    // reciprocals: floor(x / d) = (x * Recip) >> Shift over the used range
    localparam logic [23:0] Recip10k = 24'd13743896;
    localparam int Shift10k = 37;
    localparam logic [13:0] Recip10 = 14'd13108;
    localparam int Shift10 = 17;
    localparam logic [13:0] Recip100 = 14'd10486;
    localparam int Shift100 = 20;
    localparam logic [14:0] Recip1000 = 15'd16778;
    localparam int Shift1000 = 24;

    typedef struct packed {
        logic       neg;
        logic       kill;
        logic       ovr0;
        logic       ovr6;
        logic       lowmag;
        logic [6:0] lo7;
    } t_ctl;

    // charge table, entry n holds three times the charge of id n; 0 reads 0
    function automatic logic signed [3:0] charge_lut(input logic [6:0] id);
        logic signed [3:0] c;
        case (id)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd42:  c = -4'sd1;
            7'd2, 7'd4, 7'd6, 7'd8:         c = 4'sd2;
            7'd11, 7'd13, 7'd15, 7'd17:     c = -4'sd3;
            7'd24, 7'd34, 7'd37, 7'd53:     c = 4'sd3;
            7'd52, 7'd54:                   c = 4'sd6;
            default:                        c = 4'sd0;
        endcase
        return c;
    endfunction

endpackage

// File: src/particle_code_three_charge.sv
`timescale 1ns / 1ps
// a start transfer passes through registers r1 to r5; o_strobe is r5_v
// throughput: one code per cycle, busy never rises; five register stages
// (magnitude, divide by 10000, remainder, digit split, charge lookup)
// reset: synchronous active-low i_rst_n clears all stage valid bits
// the receiver cannot stall, so nothing is ever held back
module particle_code_three_charge import pctc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_particle_code,
    output logic               o_strobe,
    output logic signed [3:0]  o_three_charge
);

    logic        r1_v, r2_v, r3_v, r4_v, r5_v;
    logic        r1_neg;
    logic [31:0] r1_mag;
    t_ctl        r2_ctl, r3_ctl, r4_ctl;
    logic [23:0] r2_m;
    logic [10:0] r2_q;
    logic [13:0] r3_rem;
    logic [3:0]  r4_dj, r4_q3, r4_q2, r4_q1;
    logic signed [3:0] r5_charge;

    logic        n_accept;
    logic [31:0] n_mag;
    t_ctl        n_ctl;
    logic [47:0] n_prod;
    logic [24:0] n_sub;
    logic [27:0] n_p10, n_p100;
    logic [28:0] n_p1000;
    logic [9:0]  n_t;
    logic [6:0]  n_h;
    logic [3:0]  n_k;
    logic [6:0]  n_fid;
    logic        n_hit;
    logic signed [3:0] n_c, n_charge;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= n_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    // stage 1: magnitude and sign
    assign n_mag = i_particle_code[31] ? (~i_particle_code + 32'd1) : i_particle_code;

    always_ff @(posedge i_clk) begin
        r1_neg <= i_particle_code[31];
        r1_mag <= n_mag;
    end

    // stage 2: range checks, listed codes, quotient by 10000
    always_comb begin
        n_ctl.neg    = r1_neg;
        n_ctl.kill   = (r1_mag == 32'd0) || (r1_mag >= MagLimit);
        n_ctl.ovr0   = (r1_mag == Ovr0A) || (r1_mag == Ovr0B) || (r1_mag == Ovr0C) ||
                       (r1_mag == Ovr0D) || (r1_mag == Ovr0E) || (r1_mag == Ovr0F);
        n_ctl.ovr6   = (r1_mag == Ovr6A) || (r1_mag == Ovr6B);
        n_ctl.lowmag = (r1_mag <= FidMax);
        n_ctl.lo7    = r1_mag[6:0];
        n_prod       = 48'(r1_mag[23:0]) * 48'(Recip10k);
    end

    always_ff @(posedge i_clk) begin
        r2_ctl <= n_ctl;
        r2_m   <= r1_mag[23:0];
        r2_q   <= n_prod[Shift10k +: 11];
    end

    // stage 3: last four digits
    assign n_sub = 25'(r2_m) - 25'(r2_q) * 25'd10000;

    always_ff @(posedge i_clk) begin
        r3_ctl <= r2_ctl;
        r3_rem <= n_sub[13:0];
    end

    // stage 4: decimal digit split
    always_comb begin
        n_p10   = 28'(r3_rem) * 28'(Recip10);
        n_p100  = 28'(r3_rem) * 28'(Recip100);
        n_p1000 = 29'(r3_rem) * 29'(Recip1000);
        n_t     = n_p10[Shift10 +: 10];
        n_h     = n_p100[Shift100 +: 7];
        n_k     = n_p1000[Shift1000 +: 4];
    end

    always_ff @(posedge i_clk) begin
        r4_ctl <= r3_ctl;
        r4_dj  <= 4'(r3_rem - 14'(n_t) * 14'd10);
        r4_q3  <= 4'(n_t - 10'(n_h) * 10'd10);
        r4_q2  <= 4'(n_h - 7'(n_k) * 7'd10);
        r4_q1  <= n_k;
    end

    // stage 5: charge from the table or from the quark digits
    always_comb begin
        if (r4_q2 == 4'd0 && r4_q1 == 4'd0) begin
            n_fid = 7'(r4_q3) * 7'd10 + 7'(r4_dj);
        end else if (r4_ctl.lowmag) begin
            n_fid = r4_ctl.lo7;
        end else begin
            n_fid = 7'd0;
        end
        n_hit = (n_fid != 7'd0) && (n_fid <= FidTop);

        if (n_hit) begin
            if (r4_ctl.ovr0) begin
                n_c = 4'sd0;
            end else if (r4_ctl.ovr6) begin
                n_c = 4'sd6;
            end else begin
                n_c = charge_lut(n_fid);
            end
        end else if (r4_dj == 4'd0) begin
            n_c = 4'sd0;
        end else if (r4_q1 == 4'd0) begin
            if (r4_q2 == 4'd3 || r4_q2 == 4'd5) begin
                n_c = charge_lut(7'(r4_q3)) - charge_lut(7'(r4_q2));
            end else begin
                n_c = charge_lut(7'(r4_q2)) - charge_lut(7'(r4_q3));
            end
        end else if (r4_q3 == 4'd0) begin
            n_c = charge_lut(7'(r4_q2)) + charge_lut(7'(r4_q1));
        end else begin
            n_c = charge_lut(7'(r4_q3)) + charge_lut(7'(r4_q2)) + charge_lut(7'(r4_q1));
        end

        if (r4_ctl.kill) begin
            n_charge = 4'sd0;
        end else if (r4_ctl.neg) begin
            n_charge = -n_c;
        end else begin
            n_charge = n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_charge <= n_charge;
    end

    assign o_strobe       = r5_v;
    assign o_three_charge = r5_charge;

endmodule

// File: src/pctc_checker.sv
`timescale 1ns / 1ps
module pctc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] i_particle_code,
    input logic               o_strobe,
    input logic signed [3:0]  o_three_charge
);

    // every accepted transfer is followed by an o_strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("accepted code produced no result");

    // no result without a matching earlier transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_rst_n, 5))
        else $error("result without a matching transfer");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    a_zero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_particle_code == 32'sd0) |-> ##5 (o_three_charge == 4'sd0))
        else $error("zero code gave nonzero charge");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_three_charge != -4'sd8 && o_three_charge != -4'sd7))
        else $error("charge out of range");

endmodule

bind particle_code_three_charge pctc_checker u_pctc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_particle_code (i_particle_code),
    .o_strobe        (o_strobe),
    .o_three_charge  (o_three_charge)
);
